[rtl/bamcube_pkg.sv]
// ----------------------------------------------------------------------------
// bamcube_pkg
// shared types and constants of the bit angle modulation cube scanner
// ----------------------------------------------------------------------------
package bamcube_pkg;

    localparam int CUBE_SIDE_DEF  = 4;
    localparam int BAM_PLANES_DEF = 8;

    localparam int COORD_W       = 2;
    localparam int LEVEL_W       = 8;
    localparam int PLANE_W       = 3;
    localparam int LSEL_W        = 4;
    localparam int INTERVAL_W    = 16;
    localparam int NUM_INTERVALS = 8;
    localparam int IVAL_IDX_W    = 3;
    localparam int CFG_INDEX_W   = 4;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } ctrl_state_t;

    typedef struct packed {
        logic clear_wr;
        logic voxel_wr;
        logic scan_load;
        logic rd_en;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic col_last;
    } dp_status_t;

endpackage

[rtl/bamcube_ctrl.sv]
// ----------------------------------------------------------------------------
// bamcube_ctrl
// sequencer: clearing sweep after reset, request decode, column scan
// ----------------------------------------------------------------------------
module bamcube_ctrl
    import bamcube_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       req_type,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start && (req_type == REQ_TICK))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.col_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                busy          = 1'b0;
                cmd.voxel_wr  = start && (req_type == REQ_WRITE);
                cmd.scan_load = start && (req_type == REQ_TICK);
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.advance = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

[rtl/bamcube_dp.sv]
// ----------------------------------------------------------------------------
// bamcube_dp
// frame store, interval registers, plane and layer counters, column scan
// ----------------------------------------------------------------------------
module bamcube_dp
    import bamcube_pkg::*;
#(
    parameter int CUBE_SIDE  = CUBE_SIDE_DEF,
    parameter int BAM_PLANES = BAM_PLANES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    input  logic [COORD_W-1:0]     voxel_x,
    input  logic [COORD_W-1:0]     voxel_y,
    input  logic [COORD_W-1:0]     voxel_layer,
    input  logic [LEVEL_W-1:0]     red_level,
    input  logic [LEVEL_W-1:0]     green_level,
    input  logic [LEVEL_W-1:0]     blue_level,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [INTERVAL_W-1:0]  cfg_data,
    output logic                   result_valid,
    output logic                   red_bit,
    output logic                   green_bit,
    output logic                   blue_bit,
    output logic [LSEL_W-1:0]      layer_select_n,
    output logic [PLANE_W-1:0]     plane_index,
    output logic [INTERVAL_W-1:0]  next_interval,
    output logic                   last
);

    localparam int VOXELS = CUBE_SIDE * CUBE_SIDE * CUBE_SIDE;
    localparam int VIDX_W = $clog2(VOXELS);
    localparam int XY_W   = $clog2(CUBE_SIDE);
    localparam int WORD_W = 3 * LEVEL_W;

    logic [WORD_W-1:0]     store_mem [VOXELS];
    logic [WORD_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic                  rd_last_reg;

    logic [VIDX_W-1:0]     clr_addr_reg;
    logic [VIDX_W-1:0]     clr_addr_next;
    logic [XY_W-1:0]       col_x_reg;
    logic [XY_W-1:0]       col_x_next;
    logic [XY_W-1:0]       col_y_reg;
    logic [XY_W-1:0]       col_y_next;
    logic [XY_W-1:0]       layer_reg;
    logic [XY_W-1:0]       layer_next;
    logic [PLANE_W-1:0]    plane_reg;
    logic [PLANE_W-1:0]    plane_next;
    logic [INTERVAL_W-1:0] interval_reg [NUM_INTERVALS];

    logic                  plane_wrap;
    logic [IVAL_IDX_W-1:0] ival_idx;
    logic                  voxel_in_range;
    logic [VIDX_W-1:0]     voxel_addr;
    logic [VIDX_W-1:0]     scan_addr;
    logic                  mem_we;
    logic [VIDX_W-1:0]     mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;
    logic [LEVEL_W-1:0]    rd_red;
    logic [LEVEL_W-1:0]    rd_green;
    logic [LEVEL_W-1:0]    rd_blue;
    logic [1:0]            layer_lo;

    // write path: clearing sweep or voxel write
    assign voxel_in_range = (int'(voxel_x) < CUBE_SIDE) && (int'(voxel_y) < CUBE_SIDE)
                            && (int'(voxel_layer) < CUBE_SIDE);
    assign voxel_addr = VIDX_W'((int'(voxel_x) * CUBE_SIDE + int'(voxel_y)) * CUBE_SIDE
                                + int'(voxel_layer));
    assign scan_addr  = VIDX_W'((int'(col_x_reg) * CUBE_SIDE + int'(col_y_reg)) * CUBE_SIDE
                                + int'(layer_reg));

    assign mem_we    = cmd.clear_wr || (cmd.voxel_wr && voxel_in_range);
    assign mem_waddr = cmd.clear_wr ? clr_addr_reg : voxel_addr;
    assign mem_wdata = cmd.clear_wr ? '0 : {red_level, green_level, blue_level};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[scan_addr];
        end
    end

    // counters
    assign plane_wrap = (plane_reg == PLANE_W'(BAM_PLANES - 1));
    assign status.clear_done = (clr_addr_reg == VIDX_W'(VOXELS - 1));
    assign status.col_last   = (col_x_reg == '0) && (col_y_reg == '0);

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        col_x_next    = col_x_reg;
        col_y_next    = col_y_reg;
        plane_next    = plane_reg;
        layer_next    = layer_reg;
        if (cmd.clear_wr)
        begin
            clr_addr_next = clr_addr_reg + VIDX_W'(1);
        end
        if (cmd.scan_load)
        begin
            col_x_next = XY_W'(CUBE_SIDE - 1);
            col_y_next = XY_W'(CUBE_SIDE - 1);
        end
        else if (cmd.rd_en)
        begin
            if (col_y_reg == '0)
            begin
                col_y_next = XY_W'(CUBE_SIDE - 1);
                col_x_next = col_x_reg - XY_W'(1);
            end
            else
            begin
                col_y_next = col_y_reg - XY_W'(1);
            end
        end
        if (cmd.advance)
        begin
            if (plane_wrap)
            begin
                plane_next = '0;
                if (layer_reg == XY_W'(CUBE_SIDE - 1))
                begin
                    layer_next = '0;
                end
                else
                begin
                    layer_next = layer_reg + XY_W'(1);
                end
            end
            else
            begin
                plane_next = plane_reg + PLANE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            col_x_reg    <= '0;
            col_y_reg    <= '0;
            plane_reg    <= '0;
            layer_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            col_x_reg    <= col_x_next;
            col_y_reg    <= col_y_next;
            plane_reg    <= plane_next;
            layer_reg    <= layer_next;
            rd_valid_reg <= cmd.rd_en;
            rd_last_reg  <= cmd.rd_en && status.col_last;
        end
    end

    // interval registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_INTERVALS; i++)
            begin
                interval_reg[i] <= INTERVAL_W'(1) << i;
            end
        end
        else if (cfg_we && (int'(cfg_index) < NUM_INTERVALS))
        begin
            interval_reg[IVAL_IDX_W'(cfg_index)] <= cfg_data;
        end
    end

    // result beat
    assign ival_idx = plane_wrap ? '0 : IVAL_IDX_W'(plane_reg + PLANE_W'(1));
    assign rd_red   = rd_data_reg[3*LEVEL_W-1:2*LEVEL_W];
    assign rd_green = rd_data_reg[2*LEVEL_W-1:LEVEL_W];
    assign rd_blue  = rd_data_reg[LEVEL_W-1:0];
    assign layer_lo = 2'(layer_reg);

    assign result_valid   = rd_valid_reg;
    assign red_bit        = rd_red[plane_reg];
    assign green_bit      = rd_green[plane_reg];
    assign blue_bit       = rd_blue[plane_reg];
    assign layer_select_n = ~(LSEL_W'(1) << layer_lo);
    assign plane_index    = plane_reg;
    assign next_interval  = interval_reg[ival_idx];
    assign last           = rd_last_reg;

endmodule

[rtl/bam_led_cube_scanner_core.sv]
// a tick is accepted in the idle state, then the scan state reads the frame store
// once per column and the drain state gives the final result beat; results arrive
// one per cycle, each registered from a frame store read, and cannot be stalled
// a voxel write is taken in the idle state and produces no result
// after reset every word of the frame store is cleared, busy high
// ----------------------------------------------------------------------------
// bam_led_cube_scanner_core
// bit angle modulation scanner for an rgb led cube with serial column output
// ----------------------------------------------------------------------------
module bam_led_cube_scanner_core
    import bamcube_pkg::*;
#(
    parameter int CUBE_SIDE  = CUBE_SIDE_DEF,
    parameter int BAM_PLANES = BAM_PLANES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   req_type,
    input  logic [COORD_W-1:0]     voxel_x,
    input  logic [COORD_W-1:0]     voxel_y,
    input  logic [COORD_W-1:0]     voxel_layer,
    input  logic [LEVEL_W-1:0]     red_level,
    input  logic [LEVEL_W-1:0]     green_level,
    input  logic [LEVEL_W-1:0]     blue_level,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [INTERVAL_W-1:0]  cfg_data,
    output logic                   result_valid,
    output logic                   red_bit,
    output logic                   green_bit,
    output logic                   blue_bit,
    output logic [LSEL_W-1:0]      layer_select_n,
    output logic [PLANE_W-1:0]     plane_index,
    output logic [INTERVAL_W-1:0]  next_interval,
    output logic                   last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // start is only looked at in the idle state, where busy is low
    bamcube_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    bamcube_dp #(
        .CUBE_SIDE  (CUBE_SIDE),
        .BAM_PLANES (BAM_PLANES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .voxel_x        (voxel_x),
        .voxel_y        (voxel_y),
        .voxel_layer    (voxel_layer),
        .red_level      (red_level),
        .green_level    (green_level),
        .blue_level     (blue_level),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .red_bit        (red_bit),
        .green_bit      (green_bit),
        .blue_bit       (blue_bit),
        .layer_select_n (layer_select_n),
        .plane_index    (plane_index),
        .next_interval  (next_interval),
        .last           (last)
    );

endmodule

[sim/tb_bam_led_cube_scanner_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bam_led_cube_scanner_core
// drives voxel writes and display ticks with random gaps, tracks the cube
// contents, plane and layer counters and interval registers alongside the
// scanner, and checks every column beat against the predicted column data
// ----------------------------------------------------------------------------
module tb_bam_led_cube_scanner_core;
    import bamcube_pkg::*;

    localparam int SIDE         = CUBE_SIDE_DEF;
    localparam int PLANES       = BAM_PLANES_DEF;
    localparam int COLUMNS      = SIDE * SIDE;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 90;
    localparam int PRINT_CAP    = 50;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_UNUSED = 4'hF;

    typedef struct packed {
        logic               req_kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [LEVEL_W-1:0] r;
        logic [LEVEL_W-1:0] g;
        logic [LEVEL_W-1:0] b;
    } voxel_cmd_t;

    typedef struct packed {
        logic                  red;
        logic                  green;
        logic                  blue;
        logic [LSEL_W-1:0]     sel_n;
        logic [PLANE_W-1:0]    plane;
        logic [INTERVAL_W-1:0] interval;
        logic                  last;
    } column_beat_t;

    logic                   clk;
    logic                   rst_n       = 1'b0;
    logic                   start       = 1'b0;
    logic                   busy;
    logic                   req_type    = REQ_TICK;
    logic [COORD_W-1:0]     voxel_x     = '0;
    logic [COORD_W-1:0]     voxel_y     = '0;
    logic [COORD_W-1:0]     voxel_layer = '0;
    logic [LEVEL_W-1:0]     red_level   = '0;
    logic [LEVEL_W-1:0]     green_level = '0;
    logic [LEVEL_W-1:0]     blue_level  = '0;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [INTERVAL_W-1:0]  cfg_data    = '0;
    logic                   result_valid;
    logic                   red_bit;
    logic                   green_bit;
    logic                   blue_bit;
    logic [LSEL_W-1:0]      layer_select_n;
    logic [PLANE_W-1:0]     plane_index;
    logic [INTERVAL_W-1:0]  next_interval;
    logic                   last;

    logic [LEVEL_W-1:0]    red_store   [SIDE][SIDE][SIDE];
    logic [LEVEL_W-1:0]    green_store [SIDE][SIDE][SIDE];
    logic [LEVEL_W-1:0]    blue_store  [SIDE][SIDE][SIDE];
    logic [INTERVAL_W-1:0] interval_regs [NUM_INTERVALS];
    int unsigned           shown_plane;
    int unsigned           shown_layer;

    voxel_cmd_t   cmd_feed[$];
    column_beat_t pending_columns[$];
    voxel_cmd_t   on_port;
    column_beat_t due_beat;
    int unsigned  idle_left  = 0;
    int unsigned  steady_run = 0;
    int unsigned  mismatches = 0;

    bam_led_cube_scanner_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .voxel_x        (voxel_x),
        .voxel_y        (voxel_y),
        .voxel_layer    (voxel_layer),
        .red_level      (red_level),
        .green_level    (green_level),
        .blue_level     (blue_level),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .red_bit        (red_bit),
        .green_bit      (green_bit),
        .blue_bit       (blue_bit),
        .layer_select_n (layer_select_n),
        .plane_index    (plane_index),
        .next_interval  (next_interval),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("tb_bam_led_cube_scanner_core: errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [INTERVAL_W-1:0] got,
                                   input logic [INTERVAL_W-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    endtask

    // update the cube copy and queue the column beats a tick shifts out
    task automatic advance_cube(input voxel_cmd_t c);
        column_beat_t      beat;
        int unsigned       col;
        int unsigned       cx;
        int unsigned       cy;
        logic [LSEL_W-1:0] sel_n;
        if (c.req_kind == REQ_WRITE)
        begin
            red_store[c.x][c.y][c.z]   = c.r;
            green_store[c.x][c.y][c.z] = c.g;
            blue_store[c.x][c.y][c.z]  = c.b;
            return;
        end
        sel_n = ~({{(LSEL_W-1){1'b0}}, 1'b1} << shown_layer);
        for (int k = 0; k < COLUMNS; k++)
        begin
            col            = COLUMNS - 1 - k;
            cx             = col / SIDE;
            cy             = col % SIDE;
            beat.red       = red_store[cx][cy][shown_layer][shown_plane];
            beat.green     = green_store[cx][cy][shown_layer][shown_plane];
            beat.blue      = blue_store[cx][cy][shown_layer][shown_plane];
            beat.sel_n     = sel_n;
            beat.plane     = PLANE_W'(shown_plane);
            beat.interval  = interval_regs[(shown_plane + 1) % PLANES];
            beat.last      = (k == COLUMNS - 1);
            pending_columns.push_back(beat);
        end
        shown_plane++;
        if (shown_plane >= PLANES)
        begin
            shown_plane = 0;
            shown_layer = (shown_layer + 1) % SIDE;
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_run > 0)
        begin
            steady_run--;
            return 0;
        end
        if (roll < 4)
        begin
            steady_run = $urandom_range(8, 30);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic voxel_cmd_t make_write(input int x, input int y, input int z,
                                              input logic [LEVEL_W-1:0] r,
                                              input logic [LEVEL_W-1:0] g,
                                              input logic [LEVEL_W-1:0] b);
        voxel_cmd_t c;
        c.req_kind = REQ_WRITE;
        c.x        = COORD_W'(x);
        c.y        = COORD_W'(y);
        c.z        = COORD_W'(z);
        c.r        = r;
        c.g        = g;
        c.b        = b;
        return c;
    endfunction

    function automatic voxel_cmd_t make_tick();
        voxel_cmd_t c;
        c          = voxel_cmd_t'($urandom);
        c.req_kind = REQ_TICK;
        return c;
    endfunction

    function automatic logic [LEVEL_W-1:0] random_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return LEVEL_W'($urandom);
        endcase
    endfunction

    function automatic voxel_cmd_t random_cmd();
        if ($urandom_range(0, 99) < 55)
            return make_tick();
        return make_write($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                          $urandom_range(0, SIDE - 1), random_level(), random_level(),
                          random_level());
    endfunction

    task automatic write_interval(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [INTERVAL_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < NUM_INTERVALS)
            interval_regs[idx] = val;
        repeat ($urandom_range(0, 3)) @(posedge clk);
    endtask

    task automatic settle();
        while (cmd_feed.size() > 0 || start)
            @(posedge clk);
        while (pending_columns.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++)
            cmd_feed.push_back(random_cmd());
    endtask

    // command driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                advance_cube(on_port);
                idle_left = pick_gap();
            end
            if (start && busy)
            begin
                // hold the beat until taken
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (cmd_feed.size() > 0)
            begin
                on_port = cmd_feed.pop_front();
                req_type    <= on_port.req_kind;
                voxel_x     <= on_port.x;
                voxel_y     <= on_port.y;
                voxel_layer <= on_port.z;
                red_level   <= on_port.r;
                green_level <= on_port.g;
                blue_level  <= on_port.b;
                start       <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // column beat checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_columns.size() == 0)
            begin
                report_mismatch("column beat with none due", '0, '0);
            end
            else
            begin
                due_beat = pending_columns.pop_front();
                if (red_bit !== due_beat.red)
                    report_mismatch("red_bit", red_bit, due_beat.red);
                if (green_bit !== due_beat.green)
                    report_mismatch("green_bit", green_bit, due_beat.green);
                if (blue_bit !== due_beat.blue)
                    report_mismatch("blue_bit", blue_bit, due_beat.blue);
                if (layer_select_n !== due_beat.sel_n)
                    report_mismatch("layer_select_n", layer_select_n, due_beat.sel_n);
                if (plane_index !== due_beat.plane)
                    report_mismatch("plane_index", plane_index, due_beat.plane);
                if (next_interval !== due_beat.interval)
                    report_mismatch("next_interval", next_interval, due_beat.interval);
                if (last !== due_beat.last)
                    report_mismatch("last", last, due_beat.last);
            end
        end
    end

    initial
    begin
        for (int x = 0; x < SIDE; x++)
            for (int y = 0; y < SIDE; y++)
                for (int z = 0; z < SIDE; z++)
                begin
                    red_store[x][y][z]   = '0;
                    green_store[x][y][z] = '0;
                    blue_store[x][y][z]  = '0;
                end
        for (int i = 0; i < NUM_INTERVALS; i++)
            interval_regs[i] = INTERVAL_W'(1 << i);
        shown_plane = 0;
        shown_layer = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // reset intervals, corner voxels and an overwrite, then every plane of two layers
        cmd_feed.push_back(make_write(0, 0, 0, 8'hFF, 8'hFF, 8'hFF));
        cmd_feed.push_back(make_write(3, 3, 0, 8'h80, 8'h01, 8'hAA));
        cmd_feed.push_back(make_write(3, 0, 0, 8'h55, 8'hAA, 8'h00));
        cmd_feed.push_back(make_write(0, 3, 1, 8'h0F, 8'hF0, 8'hFF));
        cmd_feed.push_back(make_write(3, 3, 3, 8'hFF, 8'h00, 8'h80));
        cmd_feed.push_back(make_write(1, 2, 0, 8'h00, 8'h00, 8'h00));
        cmd_feed.push_back(make_write(1, 2, 0, 8'hC3, 8'h3C, 8'h99));
        for (int n = 0; n < 2 * PLANES; n++)
            cmd_feed.push_back(make_tick());
        settle();

        for (int i = 0; i < NUM_INTERVALS; i++)
            write_interval(CFG_INDEX_W'(i), '0);
        queue_random(RANDOM_ITEMS);
        settle();

        for (int i = 0; i < NUM_INTERVALS; i++)
            write_interval(CFG_INDEX_W'(i), '1);
        write_interval(CFG_IDX_UNUSED, 16'h1234);
        queue_random(RANDOM_ITEMS);
        settle();

        for (int i = 0; i < NUM_INTERVALS; i++)
            write_interval(CFG_INDEX_W'(i), INTERVAL_W'($urandom));
        queue_random(RANDOM_ITEMS);
        settle();

        for (int i = NUM_INTERVALS - 1; i >= 0; i--)
            write_interval(CFG_INDEX_W'(i), (i % 2 == 0) ? 16'hFFFF : 16'h0001);
        queue_random(RANDOM_ITEMS);
        settle();

        if (mismatches == 0)
            $display("tb_bam_led_cube_scanner_core: clean");
        else
            $display("tb_bam_led_cube_scanner_core: errors");
        $finish;
    end

endmodule
